/* hdl/drc_pkg.sv */
// ---------------------------------------------------------------------------
// drc_pkg: shared types and constants of the compact difficulty retarget unit
// Rule codes, configuration register indexes and the items that travel
// along the modulo and division cell chains.
// ---------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

    // Rule that produced a result
    typedef enum logic [2:0] {
        RULE_NONE     = 3'd0,
        RULE_INTERVAL = 3'd1,
        RULE_LIMIT    = 3'd2,
        RULE_KEPT     = 3'd3,
        RULE_EASED    = 3'd4
    } rule_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TIMESPAN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POW_LIMIT_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_RETARGET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_WINDOW     = 3'd4;

    // Block context while the height residue is worked out
    typedef struct packed {
        logic [31:0] height;
        logic [31:0] bits;
        logic [31:0] ptime;
        logic [31:0] ftime;
        logic [31:0] mtp0;
        logic [31:0] mtp6;
    } mod_item_t;

    // Sideband that rides along the division chain
    typedef struct packed {
        logic [31:0] divisor;
        rule_t       rule;
        logic [31:0] bits;
    } div_side_t;

endpackage

`default_nettype wire

/* hdl/drc_mod_cell.sv */
// ---------------------------------------------------------------------------
// drc_mod_cell: one step of the height modulo chain
// Shifts in one height bit and reduces the partial residue by the interval.
// ---------------------------------------------------------------------------
`default_nettype none

module drc_mod_cell #(
    parameter int BIT_POS = 31
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic [15:0]        divisor,
    input  wire logic               valid_in,
    input  wire drc_pkg::mod_item_t item_in,
    input  wire logic [15:0]        rem_in,
    output logic                    valid_out,
    output drc_pkg::mod_item_t      item_out,
    output logic [15:0]             rem_out
);
    import drc_pkg::*;

    logic        valid_reg;
    mod_item_t   item_reg;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [16:0] trial;

    // Restoring step on the next height bit
    always_comb begin
        trial = {rem_in, item_in.height[BIT_POS]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = 16'(trial - {1'b0, divisor});
        end else begin
            rem_next = trial[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_in;
            rem_reg  <= rem_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;
    assign rem_out   = rem_reg;

endmodule

`default_nettype wire

/* hdl/drc_prep.sv */
// ---------------------------------------------------------------------------
// drc_prep: rule selection and dividend build
// Picks the rule, clamps the span, scales the mantissa and places it at its
// byte offset, giving the dividend and divisor for the division chain.
// ---------------------------------------------------------------------------
`default_nettype none

module drc_prep #(
    parameter int TARGET_WIDTH = 256
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic [31:0]             target_timespan,
    input  wire logic [15:0]             adjust_interval,
    input  wire logic                    no_retarget,
    input  wire logic [31:0]             slow_window_seconds,
    input  wire logic [31:0]             limit_compact,
    input  wire logic                    valid_in,
    input  wire drc_pkg::mod_item_t      item_in,
    input  wire logic [15:0]             rem_in,
    output logic                         valid_out,
    output logic [TARGET_WIDTH-1:0]      dividend,
    output drc_pkg::div_side_t           side_out
);
    import drc_pkg::*;

    // Stage 1: rule, decoded mantissa, clamped span
    logic        v1_reg;
    div_side_t   s1_reg, s1_next;
    logic [22:0] w1_reg, w1_next;
    logic [10:0] sh1_reg, sh1_next;
    logic [33:0] span1_reg, span1_next;

    logic [7:0]  expo;
    logic [22:0] word;
    logic signed [34:0] sdiff, slo, shi;
    logic signed [32:0] mtp_diff;

    always_comb begin
        expo = item_in.bits[31:24];
        word = item_in.bits[22:0];
        // decode the compact word into mantissa and byte shift
        if (expo <= 8'd3) begin
            w1_next  = word >> {(2'd3 - expo[1:0]), 3'b000};
            sh1_next = '0;
        end else begin
            w1_next  = word;
            sh1_next = {8'(expo - 8'd3), 3'b000};
        end
        // clamp the span to a quarter .. four times the target span
        sdiff = 35'(signed'({1'b0, item_in.ptime}) - signed'({1'b0, item_in.ftime}));
        slo   = signed'({5'b0, target_timespan[31:2]});
        shi   = signed'({1'b0, target_timespan, 2'b00});
        if (sdiff < slo) begin
            span1_next = slo[33:0];
        end else if (sdiff > shi) begin
            span1_next = shi[33:0];
        end else begin
            span1_next = sdiff[33:0];
        end
        // pick the rule
        mtp_diff = signed'({1'b0, item_in.mtp0}) - signed'({1'b0, item_in.mtp6});
        s1_next.divisor = 32'd1;
        s1_next.bits    = item_in.bits;
        if (no_retarget) begin
            s1_next.rule = RULE_NONE;
        end else if (adjust_interval != '0 && rem_in == '0) begin
            s1_next.rule = RULE_INTERVAL;
            s1_next.divisor = (target_timespan == '0) ? 32'd1 : target_timespan;
        end else if (item_in.bits == limit_compact) begin
            s1_next.rule = RULE_LIMIT;
            s1_next.bits = limit_compact;
        end else if (mtp_diff < signed'({1'b0, slow_window_seconds})) begin
            s1_next.rule = RULE_KEPT;
        end else begin
            s1_next.rule = RULE_EASED;
        end
    end

    // Stage 2: partial products
    logic        v2_reg;
    div_side_t   s2_reg;
    logic [22:0] w2_reg;
    logic [10:0] sh2_reg;
    logic [54:0] pl2_reg;
    logic [24:0] ph2_reg;

    // Stage 3: product or plain mantissa
    logic        v3_reg;
    div_side_t   s3_reg;
    logic [10:0] sh3_reg;
    logic [56:0] x3_reg, x3_next;

    always_comb begin
        if (s2_reg.rule == RULE_INTERVAL) begin
            x3_next = 57'(pl2_reg) + {ph2_reg, 32'b0};
        end else begin
            x3_next = 57'(w2_reg);
        end
    end

    // Stage 4: place at byte offset, bits past the top are lost
    logic                    v4_reg;
    div_side_t               s4_reg;
    logic [TARGET_WIDTH-1:0] y4_reg;

    // Stage 5: ease by a quarter for every rule but the interval rule
    logic                    v5_reg;
    div_side_t               s5_reg;
    logic [TARGET_WIDTH-1:0] d5_reg, d5_next;

    always_comb begin
        if (s4_reg.rule == RULE_INTERVAL) begin
            d5_next = y4_reg;
        end else begin
            d5_next = y4_reg + (y4_reg >> 2);
        end
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg    <= s1_next;
            w1_reg    <= w1_next;
            sh1_reg   <= sh1_next;
            span1_reg <= span1_next;

            s2_reg  <= s1_reg;
            w2_reg  <= w1_reg;
            sh2_reg <= sh1_reg;
            pl2_reg <= 55'(w1_reg) * 55'(span1_reg[31:0]);
            ph2_reg <= 25'(w1_reg) * 25'(span1_reg[33:32]);

            s3_reg  <= s2_reg;
            sh3_reg <= sh2_reg;
            x3_reg  <= x3_next;

            s4_reg <= s3_reg;
            y4_reg <= TARGET_WIDTH'(x3_reg) << sh3_reg;

            s5_reg <= s4_reg;
            d5_reg <= d5_next;
        end
    end

    assign valid_out = v5_reg;
    assign dividend  = d5_reg;
    assign side_out  = s5_reg;

endmodule

`default_nettype wire

/* hdl/drc_div_cell.sv */
// ---------------------------------------------------------------------------
// drc_div_cell: one quotient bit of the target division chain
// Shifts one dividend bit into the remainder, subtracts the divisor when it
// fits and records the bit length of the quotient at its first one.
// ---------------------------------------------------------------------------
`default_nettype none

module drc_div_cell #(
    parameter int TARGET_WIDTH = 256,
    parameter int STEP         = 0,
    localparam int LEN_W       = $clog2(TARGET_WIDTH + 1)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic                    valid_in,
    input  wire logic [TARGET_WIDTH-1:0] dq_in,
    input  wire logic [31:0]             rem_in,
    input  wire logic [LEN_W-1:0]        qlen_in,
    input  wire drc_pkg::div_side_t      side_in,
    output logic                         valid_out,
    output logic [TARGET_WIDTH-1:0]      dq_out,
    output logic [31:0]                  rem_out,
    output logic [LEN_W-1:0]             qlen_out,
    output drc_pkg::div_side_t           side_out
);
    import drc_pkg::*;

    localparam logic [LEN_W-1:0] BIT_LEN = LEN_W'(TARGET_WIDTH - STEP);

    logic                    valid_reg;
    logic [TARGET_WIDTH-1:0] dq_reg, dq_next;
    logic [31:0]             rem_reg, rem_next;
    logic [LEN_W-1:0]        qlen_reg, qlen_next;
    div_side_t               side_reg;
    logic [32:0]             trial;
    logic                    qbit;

    // Restoring step: dividend bits leave at the top, quotient bits enter below
    always_comb begin
        trial = {rem_in, dq_in[TARGET_WIDTH-1]};
        qbit  = (trial >= {1'b0, side_in.divisor});
        if (qbit) begin
            rem_next = 32'(trial - {1'b0, side_in.divisor});
        end else begin
            rem_next = trial[31:0];
        end
        dq_next = {dq_in[TARGET_WIDTH-2:0], qbit};
        if (qlen_in == '0 && qbit) begin
            qlen_next = BIT_LEN;
        end else begin
            qlen_next = qlen_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            qlen_reg <= qlen_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign dq_out    = dq_reg;
    assign rem_out   = rem_reg;
    assign qlen_out  = qlen_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

/* hdl/drc_encode.sv */
// ---------------------------------------------------------------------------
// drc_encode: cap and compact encoding of the new target
// Compares the quotient with the limit, cuts out its leading three bytes and
// packs the compact word, or passes the word fixed by the rule.
// ---------------------------------------------------------------------------
`default_nettype none

module drc_encode #(
    parameter int TARGET_WIDTH = 256,
    localparam int LEN_W       = $clog2(TARGET_WIDTH + 1)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic [TARGET_WIDTH-1:0] limit_value,
    input  wire logic [31:0]             limit_compact,
    input  wire logic                    valid_in,
    input  wire logic [TARGET_WIDTH-1:0] quot,
    input  wire logic [LEN_W-1:0]        qlen,
    input  wire drc_pkg::div_side_t      side_in,
    output logic                         valid_out,
    output logic [31:0]                  next_bits,
    output logic [2:0]                   rule_used
);
    import drc_pkg::*;

    // Stage 1: cap compare and leading byte extraction
    logic             v1_reg;
    div_side_t        s1_reg;
    logic             gt1_reg;
    logic [23:0]      c1_reg, c1_next;
    logic [LEN_W-1:0] n1_reg, n1_next;
    logic [LEN_W:0]   len_p7;

    always_comb begin
        len_p7  = {1'b0, qlen} + (LEN_W+1)'(7);
        n1_next = LEN_W'(len_p7 >> 3);
        if (n1_next <= LEN_W'(3)) begin
            c1_next = quot[23:0] << {(2'd3 - n1_next[1:0]), 3'b000};
        end else begin
            c1_next = 24'(quot >> {(n1_next - LEN_W'(3)), 3'b000});
        end
    end

    // Stage 2: normalize and select the result word
    logic        v2_reg;
    logic [31:0] bits2_reg, bits2_next;
    rule_t       rule2_reg;

    always_comb begin
        if (s1_reg.rule == RULE_INTERVAL || s1_reg.rule == RULE_EASED) begin
            if (gt1_reg) begin
                bits2_next = limit_compact;
            end else if (c1_reg[23]) begin
                bits2_next = {8'(n1_reg + LEN_W'(1)), 8'b0, c1_reg[23:8]};
            end else begin
                bits2_next = {8'(n1_reg), c1_reg};
            end
        end else begin
            bits2_next = s1_reg.bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg    <= side_in;
            gt1_reg   <= (quot > limit_value);
            c1_reg    <= c1_next;
            n1_reg    <= n1_next;
            bits2_reg <= bits2_next;
            rule2_reg <= s1_reg.rule;
        end
    end

    assign valid_out = v2_reg;
    assign next_bits = bits2_reg;
    assign rule_used = rule2_reg;

endmodule

`default_nettype wire

/* hdl/difficulty_retarget_compact_unit.sv */
// ---------------------------------------------------------------------------
// difficulty_retarget_compact_unit: next compact difficulty word per block
// Takes one block context on the s_ channel and returns the compact target
// for the next block and the code of the rule that applied on the m_ channel.
//
// Usage:
//   - Items enter on s_valid/s_ready and leave on m_valid/m_ready, one result
//     per item, in order. A new item is taken each cycle the buffer has room.
//   - Items pass through 32 cells of the height modulo chain, 5 preparation
//     stages, one division cell per target bit, 2 encode stages and the
//     output buffer.
//   - A two-entry output buffer lets the chain keep taking items while a
//     result waits; the whole chain holds only once the buffer is full.
//   - Configuration registers are written through cfg_wr_en/cfg_index/
//     cfg_wr_data only while no item is in flight, a rule left to the user.
//   - Reset (aresetn low, synchronous) empties the chain and the buffer and
//     loads the default configuration.
// ---------------------------------------------------------------------------
`default_nettype none

module difficulty_retarget_compact_unit #(
    parameter int TARGET_WIDTH = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_wr_data,
    // block context
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [31:0]                    s_prev_height,
    input  wire logic [31:0]                    s_prev_bits,
    input  wire logic [31:0]                    s_prev_time,
    input  wire logic [31:0]                    s_first_time,
    input  wire logic [31:0]                    s_mtp_prev,
    input  wire logic [31:0]                    s_mtp_six_back,
    // result
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [31:0]                         m_next_bits,
    output logic [2:0]                          m_rule_used
);
    import drc_pkg::*;

    localparam int LEN_W = $clog2(TARGET_WIDTH + 1);
    localparam int MOD_STEPS = 32;

    // Configuration registers
    logic [31:0] target_timespan_reg;
    logic [15:0] adjust_interval_reg;
    logic [31:0] pow_limit_bits_reg;
    logic        no_retarget_reg;
    logic [31:0] slow_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_timespan_reg <= 32'd1209600;
            adjust_interval_reg <= 16'd2016;
            pow_limit_bits_reg  <= 32'h1d00ffff;
            no_retarget_reg     <= 1'b0;
            slow_window_reg     <= 32'd43200;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET_TIMESPAN: target_timespan_reg <= cfg_wr_data;
                CFG_ADJUST_INTERVAL: adjust_interval_reg <= cfg_wr_data[15:0];
                CFG_POW_LIMIT_BITS:  pow_limit_bits_reg  <= cfg_wr_data;
                CFG_NO_RETARGET:     no_retarget_reg     <= cfg_wr_data[0];
                CFG_SLOW_WINDOW:     slow_window_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Limit target and its canonical compact word, derived from the register
    logic [TARGET_WIDTH-1:0] limit_value_reg;
    logic [31:0]             limit_compact_reg, limit_compact_next;
    logic [7:0]              lim_expo;
    logic [22:0]             lim_raw, lim_m;
    logic [10:0]             lim_sh;
    logic [7:0]              lim_k;
    logic [4:0]              lim_blen;
    logic [1:0]              lim_nm;
    logic [8:0]              lim_n;
    logic [23:0]             lim_c;

    always_comb begin
        lim_expo = pow_limit_bits_reg[31:24];
        if (lim_expo <= 8'd3) begin
            lim_raw = pow_limit_bits_reg[22:0] >> {(2'd3 - lim_expo[1:0]), 3'b000};
            lim_k   = '0;
        end else begin
            lim_raw = pow_limit_bits_reg[22:0];
            lim_k   = lim_expo - 8'd3;
        end
        lim_sh = {lim_k, 3'b000};
        // drop mantissa bits that land past the target width
        for (int p = 0; p < 23; p++) begin
            lim_m[p] = lim_raw[p] && ((int'(lim_sh) + p) < TARGET_WIDTH);
        end
        lim_blen = '0;
        for (int p = 0; p < 23; p++) begin
            if (lim_m[p]) begin
                lim_blen = 5'(p + 1);
            end
        end
        lim_nm = 2'((lim_blen + 5'd7) >> 3);
        lim_n  = (lim_m == '0) ? 9'd0 : ({1'b0, lim_k} + 9'(lim_nm));
        lim_c  = {1'b0, lim_m} << {(2'd3 - lim_nm), 3'b000};
        if (lim_c[23]) begin
            limit_compact_next = {8'(lim_n + 9'd1), 8'b0, lim_c[23:8]};
        end else begin
            limit_compact_next = {lim_n[7:0], lim_c};
        end
    end

    always_ff @(posedge aclk) begin
        limit_value_reg   <= TARGET_WIDTH'(lim_m) << lim_sh;
        limit_compact_reg <= limit_compact_next;
    end

    // Output buffer and chain advance
    logic        adv;
    logic        enc_valid;
    logic [31:0] enc_bits;
    logic [2:0]  enc_rule;
    logic [1:0]  count_reg;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [31:0] buf_bits_reg [2];
    logic [2:0]  buf_rule_reg [2];
    logic        push, pop;

    assign adv     = (count_reg != 2'd2);
    assign s_ready = adv;
    assign push    = adv && enc_valid;
    assign pop     = m_valid && m_ready;

    // Height modulo chain
    logic      mod_valid [MOD_STEPS+1];
    mod_item_t mod_item  [MOD_STEPS+1];
    logic [15:0] mod_rem [MOD_STEPS+1];

    assign mod_valid[0]      = s_valid;
    assign mod_item[0].height = s_prev_height + 32'd1;
    assign mod_item[0].bits   = s_prev_bits;
    assign mod_item[0].ptime  = s_prev_time;
    assign mod_item[0].ftime  = s_first_time;
    assign mod_item[0].mtp0   = s_mtp_prev;
    assign mod_item[0].mtp6   = s_mtp_six_back;
    assign mod_rem[0]         = '0;

    for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
        drc_mod_cell #(
            .BIT_POS(MOD_STEPS - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .divisor   (adjust_interval_reg),
            .valid_in  (mod_valid[i]),
            .item_in   (mod_item[i]),
            .rem_in    (mod_rem[i]),
            .valid_out (mod_valid[i+1]),
            .item_out  (mod_item[i+1]),
            .rem_out   (mod_rem[i+1])
        );
    end

    // Rule selection and dividend build
    logic                    div_valid [TARGET_WIDTH+1];
    logic [TARGET_WIDTH-1:0] div_dq    [TARGET_WIDTH+1];
    logic [31:0]             div_rem   [TARGET_WIDTH+1];
    logic [LEN_W-1:0]        div_qlen  [TARGET_WIDTH+1];
    div_side_t               div_side  [TARGET_WIDTH+1];

    drc_prep #(
        .TARGET_WIDTH(TARGET_WIDTH)
    ) u_prep (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .adv                 (adv),
        .target_timespan     (target_timespan_reg),
        .adjust_interval     (adjust_interval_reg),
        .no_retarget         (no_retarget_reg),
        .slow_window_seconds (slow_window_reg),
        .limit_compact       (limit_compact_reg),
        .valid_in            (mod_valid[MOD_STEPS]),
        .item_in             (mod_item[MOD_STEPS]),
        .rem_in              (mod_rem[MOD_STEPS]),
        .valid_out           (div_valid[0]),
        .dividend            (div_dq[0]),
        .side_out            (div_side[0])
    );

    assign div_rem[0]  = '0;
    assign div_qlen[0] = '0;

    // Division chain, one quotient bit per cell
    for (genvar j = 0; j < TARGET_WIDTH; j++) begin : g_div
        drc_div_cell #(
            .TARGET_WIDTH(TARGET_WIDTH),
            .STEP        (j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (div_valid[j]),
            .dq_in     (div_dq[j]),
            .rem_in    (div_rem[j]),
            .qlen_in   (div_qlen[j]),
            .side_in   (div_side[j]),
            .valid_out (div_valid[j+1]),
            .dq_out    (div_dq[j+1]),
            .rem_out   (div_rem[j+1]),
            .qlen_out  (div_qlen[j+1]),
            .side_out  (div_side[j+1])
        );
    end

    // Cap and encode
    drc_encode #(
        .TARGET_WIDTH(TARGET_WIDTH)
    ) u_encode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .limit_value   (limit_value_reg),
        .limit_compact (limit_compact_reg),
        .valid_in      (div_valid[TARGET_WIDTH]),
        .quot          (div_dq[TARGET_WIDTH]),
        .qlen          (div_qlen[TARGET_WIDTH]),
        .side_in       (div_side[TARGET_WIDTH]),
        .valid_out     (enc_valid),
        .next_bits     (enc_bits),
        .rule_used     (enc_rule)
    );

    // Output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Hold buffered items
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_bits_reg[wr_ptr_reg] <= enc_bits;
            buf_rule_reg[wr_ptr_reg] <= enc_rule;
        end
    end

    assign m_valid     = (count_reg != 2'd0);
    assign m_next_bits = buf_bits_reg[rd_ptr_reg];
    assign m_rule_used = buf_rule_reg[rd_ptr_reg];

    // Unused final remainder is dropped
    logic unused_rem;
    assign unused_rem = ^div_rem[TARGET_WIDTH];

endmodule

`default_nettype wire

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb: testbench of the compact difficulty retarget unit
// Sends block contexts through the valid/ready input, predicts each next
// compact word and rule code with a 256-bit model kept here, and checks
// every result in order. Covers directed corner cases, every rule, all
// configuration registers at their extremes, and a long random run with
// stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import drc_pkg::*;

    localparam int TW = 256;
    localparam int LATENCY = TW + 40;

    typedef struct {
        logic [31:0] height;
        logic [31:0] bits;
        logic [31:0] ptime;
        logic [31:0] ftime;
        logic [31:0] mtp0;
        logic [31:0] mtp6;
    } block_ctx_t;

    typedef struct {
        logic [31:0] next_bits;
        rule_t       rule;
    } retarget_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_prev_height, s_prev_bits, s_prev_time;
    logic [31:0] s_first_time, s_mtp_prev, s_mtp_six_back;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_next_bits;
    logic [2:0]  m_rule_used;

    // Shadow copy of the configuration
    logic [31:0] cfg_timespan;
    logic [15:0] cfg_interval;
    logic [31:0] cfg_limit_bits;
    logic        cfg_frozen;
    logic [31:0] cfg_window;

    retarget_t expected_words[$];
    int        error_count;
    int        blocks_sent;
    int        words_checked;
    int        rule_hits[5];
    bit        idle_on;
    int        ready_stall;

    difficulty_retarget_compact_unit #(.TARGET_WIDTH(TW)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_prev_height (s_prev_height),
        .s_prev_bits   (s_prev_bits),
        .s_prev_time   (s_prev_time),
        .s_first_time  (s_first_time),
        .s_mtp_prev    (s_mtp_prev),
        .s_mtp_six_back(s_mtp_six_back),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_bits   (m_next_bits),
        .m_rule_used   (m_rule_used)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Expand a compact word to a full-width target; the sign bit is dropped
    function automatic logic [TW-1:0] expand_compact(logic [31:0] word);
        logic [7:0]    expo;
        logic [TW-1:0] mant;
        expo = word[31:24];
        mant = TW'(word[22:0]);
        if (expo <= 8'd3)
            return mant >> (8 * (3 - expo));
        return mant << (8 * (int'(expo) - 3));
    endfunction

    // Pack a target back to canonical compact form
    function automatic logic [31:0] pack_compact(logic [TW-1:0] tgt);
        int          len;
        int          nbytes;
        logic [31:0] mant;
        len = 0;
        for (int i = TW - 1; i >= 0; i--) begin
            if (tgt[i] && len == 0) len = i + 1;
        end
        nbytes = (len + 7) / 8;
        if (nbytes <= 3)
            mant = tgt[31:0] << (8 * (3 - nbytes));
        else
            mant = 32'(tgt >> (8 * (nbytes - 3)));
        mant &= 32'h00FF_FFFF;
        if (mant[23]) begin
            mant >>= 8;
            nbytes++;
        end
        return mant | (32'(nbytes) << 24);
    endfunction

    // Work out the next compact word and the rule for one block context
    function automatic retarget_t next_target_word(block_ctx_t ctx);
        retarget_t     r;
        logic [31:0]   next_h;
        logic [TW-1:0] limit;
        logic [TW-1:0] tgt;
        logic [31:0]   limit_word;
        longint        span;
        longint        ts;
        if (cfg_frozen) begin
            r.next_bits = ctx.bits;
            r.rule = RULE_NONE;
            return r;
        end
        next_h = ctx.height + 32'd1;
        limit = expand_compact(cfg_limit_bits);
        limit_word = pack_compact(limit);
        if (cfg_interval != 0 && next_h % cfg_interval == 0) begin
            ts = longint'({32'd0, cfg_timespan});
            span = longint'({32'd0, ctx.ptime}) - longint'({32'd0, ctx.ftime});
            if (span < ts / 4) span = ts / 4;
            if (span > ts * 4) span = ts * 4;
            tgt = expand_compact(ctx.bits) * TW'(span);
            tgt = tgt / TW'(cfg_timespan != 0 ? cfg_timespan : 32'd1);
            if (tgt > limit) tgt = limit;
            r.next_bits = pack_compact(tgt);
            r.rule = RULE_INTERVAL;
        end else if (ctx.bits == limit_word) begin
            r.next_bits = limit_word;
            r.rule = RULE_LIMIT;
        end else if (longint'({32'd0, ctx.mtp0}) - longint'({32'd0, ctx.mtp6})
                     < longint'({32'd0, cfg_window})) begin
            r.next_bits = ctx.bits;
            r.rule = RULE_KEPT;
        end else begin
            tgt = expand_compact(ctx.bits);
            tgt = tgt + (tgt >> 2);
            if (tgt > limit) tgt = limit;
            r.next_bits = pack_compact(tgt);
            r.rule = RULE_EASED;
        end
        return r;
    endfunction

    // Check each result against the oldest expected word
    always @(posedge aclk) begin
        retarget_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result: next_bits=%h rule_used=%0d",
                       m_next_bits, m_rule_used);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (m_next_bits !== want.next_bits) begin
                    $error("next_bits mismatch: expected %h, actual %h",
                           want.next_bits, m_next_bits);
                    error_count++;
                end
                if (m_rule_used !== want.rule) begin
                    $error("rule_used mismatch: expected %0d, actual %0d",
                           want.rule, m_rule_used);
                    error_count++;
                end
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall--;
            m_ready = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_stall = $urandom_range(0, 8);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Send one item; called at a falling edge, returns at a falling edge
    task automatic send_block(block_ctx_t ctx);
        retarget_t want;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_prev_height  = ctx.height;
        s_prev_bits    = ctx.bits;
        s_prev_time    = ctx.ptime;
        s_first_time   = ctx.ftime;
        s_mtp_prev     = ctx.mtp0;
        s_mtp_six_back = ctx.mtp6;
        want = next_target_word(ctx);
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(want);
        rule_hits[want.rule]++;
        blocks_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Hold until every expected result has come
    task automatic wait_drain();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        wait_drain();
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        case (idx)
            CFG_TARGET_TIMESPAN: cfg_timespan = data;
            CFG_ADJUST_INTERVAL: cfg_interval = data[15:0];
            CFG_POW_LIMIT_BITS:  cfg_limit_bits = data;
            CFG_NO_RETARGET:     cfg_frozen = data[0];
            CFG_SLOW_WINDOW:     cfg_window = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        @(negedge aclk);
    endtask

    function automatic block_ctx_t make_ctx(logic [31:0] h, logic [31:0] b,
                                            logic [31:0] pt, logic [31:0] ft,
                                            logic [31:0] m0, logic [31:0] m6);
        block_ctx_t c;
        c.height = h;
        c.bits   = b;
        c.ptime  = pt;
        c.ftime  = ft;
        c.mtp0   = m0;
        c.mtp6   = m6;
        return c;
    endfunction

    // Random context, mostly shaped to land on each rule
    function automatic block_ctx_t random_ctx();
        block_ctx_t c;
        int         pick;
        c = make_ctx($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 9);
        // height on or near an interval boundary
        if (pick < 4 && cfg_interval != 0)
            c.height = cfg_interval * $urandom_range(0, 5000) - 1;
        // realistic compact words, or the limit itself
        case ($urandom_range(0, 5))
            0: c.bits = cfg_limit_bits;
            1, 2: c.bits = {8'($urandom_range(0, 34)), 24'($urandom)} & 32'hFF7F_FFFF;
            3: c.bits = {8'($urandom_range(0, 4)), 24'($urandom)};
            default: ;
        endcase
        // spans close to the target timespan
        if ($urandom_range(0, 2) != 0)
            c.ftime = c.ptime - $urandom_range(0, 6) * (cfg_timespan / 4)
                      - $urandom_range(0, 100);
        // median-time spans near the window
        if ($urandom_range(0, 2) != 0)
            c.mtp6 = c.mtp0 - cfg_window + $urandom_range(0, 20) - 10;
        return c;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_block(random_ctx());
    endtask

    task automatic test_directed();
        send_block(make_ctx(32'd2015, 32'h1d00ffff, 32'd1209600, 32'd0, 0, 0));
        send_block(make_ctx(32'd2015, 32'h1b0404cb, 32'hFFFF_FFFF, 32'd0, 0, 0));
        send_block(make_ctx(32'd4031, 32'h1b0404cb, 32'd0, 32'hFFFF_FFFF, 0, 0));
        send_block(make_ctx(32'd4031, 32'h1b0404cb, 32'd100, 32'd50, 0, 0));
        send_block(make_ctx(32'hFFFF_FFFF, 32'h1a05db8b, 32'd500000, 32'd0, 0, 0));
        send_block(make_ctx(32'd10, 32'h1d00ffff, 0, 0, 32'd100000, 0));
        send_block(make_ctx(32'd10, 32'h1c00ffff, 0, 0, 32'd43199, 0));
        send_block(make_ctx(32'd10, 32'h1c00ffff, 0, 0, 32'd43200, 0));
        send_block(make_ctx(32'd10, 32'h1c00ffff, 0, 0, 0, 32'hFFFF_FFFF));
        send_block(make_ctx(32'd10, 32'h1c7fffff, 0, 0, 32'hFFFF_FFFF, 0));
        send_block(make_ctx(32'd10, 32'h1c80ffff, 0, 0, 32'hFFFF_FFFF, 0));
        send_block(make_ctx(32'd10, 32'h00000000, 0, 0, 32'hFFFF_FFFF, 0));
        send_block(make_ctx(32'd10, 32'h03123456, 0, 0, 32'hFFFF_FFFF, 0));
        send_block(make_ctx(32'd10, 32'h01ffffff, 0, 0, 32'hFFFF_FFFF, 0));
        send_block(make_ctx(32'd2015, 32'hFF7FFFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_block(make_ctx(32'd2015, 32'h22ffffff, 32'd2000000, 0, 0, 0));
        send_block(make_ctx(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_frozen();
        write_reg(CFG_NO_RETARGET, 32'hFFFF_FFFF);
        send_block(make_ctx(32'd2015, 32'h1b0404cb, 32'hFFFF_FFFF, 0, 0, 0));
        run_random(20);
        write_reg(CFG_NO_RETARGET, 32'd0);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_TARGET_TIMESPAN, 32'd0);
        write_reg(CFG_ADJUST_INTERVAL, 32'd1);
        send_block(make_ctx(32'd7, 32'h1b0404cb, 32'd100, 32'd0, 0, 0));
        run_random(20);
        write_reg(CFG_TARGET_TIMESPAN, 32'hFFFF_FFFF);
        run_random(20);
        write_reg(CFG_ADJUST_INTERVAL, 32'd0);
        send_block(make_ctx(32'hFFFF_FFFF, 32'h1b0404cb, 0, 0, 0, 0));
        run_random(20);
        write_reg(CFG_ADJUST_INTERVAL, 32'hFFFF_FFFF);
        run_random(20);
        write_reg(CFG_POW_LIMIT_BITS, 32'd0);
        run_random(20);
        write_reg(CFG_POW_LIMIT_BITS, 32'hFFFF_FFFF);
        run_random(20);
        write_reg(CFG_POW_LIMIT_BITS, 32'h2000ffff);
        run_random(20);
        write_reg(CFG_SLOW_WINDOW, 32'd0);
        run_random(20);
        write_reg(CFG_SLOW_WINDOW, 32'hFFFF_FFFF);
        run_random(20);
    endtask

    task automatic test_random_configs();
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_TARGET_TIMESPAN, $urandom_range(0, 3) == 0 ? $urandom
                                           : $urandom_range(1, 3000000));
            write_reg(CFG_ADJUST_INTERVAL, $urandom_range(0, 3) == 0 ? $urandom
                                           : $urandom_range(1, 3000));
            write_reg(CFG_POW_LIMIT_BITS, $urandom_range(0, 1) == 0 ? $urandom
                                          : {8'($urandom_range(3, 33)), 24'($urandom)});
            write_reg(CFG_SLOW_WINDOW, $urandom_range(0, 3) == 0 ? $urandom
                                       : $urandom_range(0, 100000));
            if (phase == 5) idle_on = 1'b0;
            run_random(100);
            // let the pipe run dry once mid-phase
            if (phase == 2) wait_drain();
            run_random(100);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_prev_height = '0;
        s_prev_bits = '0;
        s_prev_time = '0;
        s_first_time = '0;
        s_mtp_prev = '0;
        s_mtp_six_back = '0;
        m_ready = 1'b0;
        ready_stall = 0;
        idle_on = 1'b1;
        error_count = 0;
        blocks_sent = 0;
        words_checked = 0;
        cfg_timespan = 32'd1209600;
        cfg_interval = 16'd2016;
        cfg_limit_bits = 32'h1d00ffff;
        cfg_frozen = 1'b0;
        cfg_window = 32'd43200;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_frozen();
        write_reg(CFG_TARGET_TIMESPAN, 32'd1209600);
        write_reg(CFG_ADJUST_INTERVAL, 32'd2016);
        write_reg(CFG_POW_LIMIT_BITS, 32'h1d00ffff);
        write_reg(CFG_SLOW_WINDOW, 32'd43200);
        run_random(60);
        test_register_extremes();
        test_random_configs();

        wait_drain();
        repeat (LATENCY + 20) @(posedge aclk);
        if (expected_words.size() != 0) begin
            $error("%0d results never arrived", expected_words.size());
            error_count++;
        end
        $display("Sent %0d block contexts, checked %0d results", blocks_sent,
                 words_checked);
        $display("Rules hit: none %0d, interval %0d, limit %0d, kept %0d, eased %0d",
                 rule_hits[0], rule_hits[1], rule_hits[2], rule_hits[3], rule_hits[4]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #8ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
hdl/drc_pkg.sv
hdl/drc_mod_cell.sv
hdl/drc_prep.sv
hdl/drc_div_cell.sv
hdl/drc_encode.sv
hdl/difficulty_retarget_compact_unit.sv
test/tb.sv
